// ----- hw/rtl/ists_pkg.sv -----
// shared types and codes for the imu spi transfer scheduler
package ists_pkg;

    // event codes carried by one input beat
    typedef enum logic [1:0] {
        KIND_ACCEL_READY = 2'd0,
        KIND_GYRO_READY  = 2'd1,
        KIND_XFER_DONE   = 2'd2,
        KIND_CONSUME     = 2'd3
    } kind_t;

    // source codes for a started transfer
    typedef enum logic [1:0] {
        SRC_NONE  = 2'd0,
        SRC_GYRO  = 2'd1,
        SRC_ACCEL = 2'd2,
        SRC_TEMP  = 2'd3
    } src_t;

    // per-source flags
    typedef struct packed {
        logic updated;
        logic xfer;
        logic ready;
    } flags_t;

    // one accepted input beat
    typedef struct packed {
        kind_t kind;
        logic  link_busy;
    } event_t;

    // one result beat
    typedef struct packed {
        src_t start_source;
        logic release_gyro_select;
        logic release_accel_select;
        logic gyro_fresh;
        logic accel_fresh;
        logic temp_fresh;
    } result_t;

endpackage

// ----- hw/rtl/imu_spi_transfer_scheduler.sv -----
// top level of the imu spi transfer scheduler
// Each event beat (accel ready, gyro ready, transfer complete, consume) gives
// exactly one result beat. The block takes one event per clock unless it is
// stalled by out_ready. An accepted beat sits in an input register. Once the
// result register has room, the scheduling logic updates the gyro, accel and
// temperature flags and loads the result register, so the throughput is
// one beat per cycle whenever the consumer keeps out_ready high. While
// out_ready is low the block holds two beats, one in each register, and then
// drops in_ready. The enable register is written through the cfg channel,
// which is always ready; write it only while no event is in flight.
module imu_spi_transfer_scheduler (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  logic       link_busy,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] start_source,
    output logic       release_gyro_select,
    output logic       release_accel_select,
    output logic       gyro_fresh,
    output logic       accel_fresh,
    output logic       temp_fresh,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);
    import ists_pkg::*;

    event_t  in_event;
    event_t  ev_data;
    logic    ev_valid;
    logic    can_load;
    logic    fire;
    result_t sched_res;
    result_t out_res;

    assign in_event.kind      = kind_t'(kind);
    assign in_event.link_busy = link_busy;
    assign cfg_ready          = 1'b1;

    // a held event is processed when the result register has room
    assign fire = ev_valid && can_load;

    ists_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_event (in_event),
        .ev_valid (ev_valid),
        .ev_take  (fire),
        .ev_data  (ev_data)
    );

    ists_sched u_sched (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .ev        (ev_data),
        .result    (sched_res)
    );

    ists_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .can_load  (can_load),
        .res_in    (sched_res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_out   (out_res)
    );

    assign start_source         = out_res.start_source;
    assign release_gyro_select  = out_res.release_gyro_select;
    assign release_accel_select = out_res.release_accel_select;
    assign gyro_fresh           = out_res.gyro_fresh;
    assign accel_fresh          = out_res.accel_fresh;
    assign temp_fresh           = out_res.temp_fresh;

endmodule

// ----- hw/rtl/ists_in_stage.sv -----
// input register stage holding one accepted event beat
module ists_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ists_pkg::event_t in_event,
    output logic            ev_valid,
    input  logic            ev_take,
    output ists_pkg::event_t ev_data
);
    import ists_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    event_t data_reg;

    // free when empty or when the held beat moves on this cycle
    assign in_ready   = !valid_reg || ev_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !ev_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_event;
        end
    end

    assign ev_valid = valid_reg;
    assign ev_data  = data_reg;

endmodule

// ----- hw/rtl/ists_sched.sv -----
// source flags, enable register and combinational scheduling logic
module ists_sched (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic              cfg_data,
    input  logic              fire,
    input  ists_pkg::event_t  ev,
    output ists_pkg::result_t result
);
    import ists_pkg::*;

    flags_t  gyro_reg, accel_reg, temp_reg;
    flags_t  gyro_next, accel_next, temp_next;
    logic    enable_reg;
    logic    try_start;
    result_t res;

    // enable register, written by the user only while idle; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            enable_reg <= cfg_data;
        end
    end

    // event handling and fixed-priority start
    always_comb
    begin
        gyro_next  = gyro_reg;
        accel_next = accel_reg;
        temp_next  = temp_reg;
        res        = '0;
        res.start_source = SRC_NONE;
        try_start  = 1'b0;

        case (ev.kind)
            KIND_ACCEL_READY:
            begin
                accel_next.ready = 1'b1;
                temp_next.ready  = 1'b1;
                try_start        = enable_reg;
            end
            KIND_GYRO_READY:
            begin
                gyro_next.ready = 1'b1;
                try_start       = enable_reg;
            end
            KIND_XFER_DONE:
            begin
                // finished sources become updated and release their select
                if (gyro_reg.xfer)
                begin
                    gyro_next.xfer    = 1'b0;
                    gyro_next.updated = 1'b1;
                    res.release_gyro_select = 1'b1;
                end
                if (accel_reg.xfer)
                begin
                    accel_next.xfer    = 1'b0;
                    accel_next.updated = 1'b1;
                    res.release_accel_select = 1'b1;
                end
                if (temp_reg.xfer)
                begin
                    temp_next.xfer    = 1'b0;
                    temp_next.updated = 1'b1;
                    res.release_accel_select = 1'b1;
                end
                try_start = 1'b1;
            end
            KIND_CONSUME:
            begin
                res.gyro_fresh     = gyro_reg.updated;
                res.accel_fresh    = accel_reg.updated;
                res.temp_fresh     = temp_reg.updated;
                gyro_next.updated  = 1'b0;
                accel_next.updated = 1'b0;
                temp_next.updated  = 1'b0;
            end
            default:
            begin
                try_start = 1'b0;
            end
        endcase

        // on a start attempt with the link free, a ready source starts when neither other source is in transfer
        if (try_start && !ev.link_busy)
        begin
            if (gyro_next.ready && !accel_next.xfer && !temp_next.xfer)
            begin
                gyro_next.ready  = 1'b0;
                gyro_next.xfer   = 1'b1;
                res.start_source = SRC_GYRO;
            end
            else if (accel_next.ready && !gyro_next.xfer && !temp_next.xfer)
            begin
                accel_next.ready = 1'b0;
                accel_next.xfer  = 1'b1;
                res.start_source = SRC_ACCEL;
            end
            else if (temp_next.ready && !gyro_next.xfer && !accel_next.xfer)
            begin
                temp_next.ready  = 1'b0;
                temp_next.xfer   = 1'b1;
                res.start_source = SRC_TEMP;
            end
        end
    end

    // flag state advances once per processed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_reg  <= '0;
            accel_reg <= '0;
            temp_reg  <= '0;
        end
        else if (fire)
        begin
            gyro_reg  <= gyro_next;
            accel_reg <= accel_next;
            temp_reg  <= temp_next;
        end
    end

    assign result = res;

endmodule

// ----- hw/rtl/ists_out_stage.sv -----
// result register stage toward the downstream consumer
module ists_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    output logic              can_load,
    input  ists_pkg::result_t res_in,
    output logic              out_valid,
    input  logic              out_ready,
    output ists_pkg::result_t res_out
);
    import ists_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // room when empty or the held beat leaves this cycle
    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = data_reg;

endmodule

// ----- hw/rtl/ists_checker.sv -----
// port-level checks for the imu spi transfer scheduler, bound to the top level
module ists_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] start_source,
    input logic       release_gyro_select,
    input logic       release_accel_select,
    input logic       gyro_fresh,
    input logic       accel_fresh,
    input logic       temp_fresh
);
    import ists_pkg::*;

    // a stalled result beat holds its start source and release payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(start_source)
            && $stable(release_gyro_select) && $stable(release_accel_select))
        else $error("result beat changed while stalled");

    // fresh bits only come with a consume, which starts nothing
    a_fresh_no_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (gyro_fresh || accel_fresh || temp_fresh)
            |-> start_source == SRC_NONE)
        else $error("fresh report together with a start");

    // releases and fresh reports belong to different event kinds
    a_release_vs_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (release_gyro_select || release_accel_select)
            |-> !(gyro_fresh || accel_fresh || temp_fresh))
        else $error("release and fresh report in one beat");

    // a new result beat must come from an accepted event held in the input register
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result beat without an accepted event");

endmodule

bind imu_spi_transfer_scheduler ists_checker u_ists_checker (.*);
